/* rtl/rac_pkg.sv */
package rac_pkg;

  localparam int unsigned CountWidth  = 21;
  localparam int unsigned LengthWidth = 30;
  localparam int unsigned IndexWidth  = 20;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_TYPE  = 3'd1;
  localparam logic [2:0] ERR_DIGIT = 3'd2;
  localparam logic [2:0] ERR_LF    = 3'd3;
  localparam logic [2:0] ERR_NEG   = 3'd4;
  localparam logic [2:0] ERR_LIMIT = 3'd5;

  localparam logic [CountWidth-1:0]  COUNT_LIMIT_RESET  = 21'd1048576;
  localparam logic [LengthWidth-1:0] LENGTH_LIMIT_RESET = 30'd536870912;

  localparam logic REG_COUNT_LIMIT  = 1'b0;
  localparam logic REG_LENGTH_LIMIT = 1'b1;

  typedef struct packed {
    logic [2:0]             err;
    logic                   at_cr;
    logic [LengthWidth-1:0] acc;
    logic                   digits_seen;
    logic                   sign_seen;
  } num_step_t;

  typedef struct packed {
    logic                   payload_valid;
    logic [7:0]             payload_byte;
    logic [IndexWidth-1:0]  arg_index;
    logic                   arg_done;
    logic                   command_done;
    logic [CountWidth-1:0]  arg_total;
    logic [2:0]             error_code;
  } result_t;

endpackage

/* rtl/rac_byte_if.sv */
interface rac_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

/* rtl/rac_result_if.sv */
interface rac_result_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [19:0] arg_index;
  logic        arg_done;
  logic        command_done;
  logic [20:0] arg_total;
  logic [2:0]  error_code;

  modport source (
    output valid, output payload_valid, output payload_byte, output arg_index,
    output arg_done, output command_done, output arg_total, output error_code,
    input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input arg_index,
    input arg_done, input command_done, input arg_total, input error_code,
    output ready
  );
endinterface

/* rtl/rac_apb_regs.sv */
module rac_apb_regs
  import rac_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output logic [CountWidth-1:0]  count_limit,
  output logic [LengthWidth-1:0] length_limit
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit  <= COUNT_LIMIT_RESET;
      length_limit <= LENGTH_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_COUNT_LIMIT:  count_limit  <= pwdata[CountWidth-1:0];
        REG_LENGTH_LIMIT: length_limit <= pwdata[LengthWidth-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COUNT_LIMIT:  prdata = {{(32-CountWidth){1'b0}}, count_limit};
      REG_LENGTH_LIMIT: prdata = {{(32-LengthWidth){1'b0}}, length_limit};
    endcase
  end

endmodule

/* rtl/rac_number.sv */
module rac_number
  import rac_pkg::*;
(
  input  logic [7:0]             data,
  input  logic [LengthWidth-1:0] acc,
  input  logic                   digits_seen,
  input  logic                   sign_seen,
  input  logic [LengthWidth-1:0] limit,
  output num_step_t              step
);

  logic [LengthWidth+3:0] acc_wide;
  logic [LengthWidth+3:0] value;
  logic                   is_digit;

  assign acc_wide = {4'b0, acc};
  assign value    = (acc_wide << 3) + (acc_wide << 1) + {{LengthWidth{1'b0}}, data[3:0]};
  assign is_digit = (data >= CH_ZERO) && (data <= CH_NINE);

  always_comb begin
    step             = '0;
    step.acc         = acc;
    step.digits_seen = digits_seen;
    step.sign_seen   = sign_seen;
    if (is_digit) begin
      if (value > {4'b0, limit}) begin
        step.err = ERR_LIMIT;
      end else begin
        step.acc         = value[LengthWidth-1:0];
        step.digits_seen = 1'b1;
      end
    end else if (data == CH_MINUS && !digits_seen && !sign_seen) begin
      step.sign_seen = 1'b1;
    end else if (data == CH_CR) begin
      if (!digits_seen) begin
        step.err = ERR_DIGIT;
      end else if (sign_seen) begin
        step.err = ERR_NEG;
      end else begin
        step.at_cr = 1'b1;
      end
    end else begin
      step.err = ERR_DIGIT;
    end
  end

endmodule

/* rtl/rac_parser.sv */
module rac_parser
  import rac_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CountWidth-1:0]  count_limit,
  input  logic [LengthWidth-1:0] length_limit,
  rac_byte_if.sink               stream,
  rac_result_if.source           result
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_CNT_NUM  = 3'd1;
  localparam logic [2:0] PH_CNT_LF   = 3'd2;
  localparam logic [2:0] PH_ARG_TYPE = 3'd3;
  localparam logic [2:0] PH_LEN_NUM  = 3'd4;
  localparam logic [2:0] PH_LEN_LF   = 3'd5;
  localparam logic [2:0] PH_PAYLOAD  = 3'd6;
  localparam logic [2:0] PH_TRAILER  = 3'd7;

  typedef struct packed {
    logic [2:0]             phase;
    logic [LengthWidth-1:0] acc;
    logic                   digits_seen;
    logic                   sign_seen;
    logic [CountWidth-1:0]  args_total;
    logic [CountWidth-1:0]  current_arg;
    logic [LengthWidth-1:0] bytes_left;
    logic [1:0]             trailer_left;
  } parse_state_t;

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   advance;
  logic                   out_valid;
  result_t                res;
  result_t                res_next;
  parse_state_t           st;
  parse_state_t           st_next;
  num_step_t              num;
  logic [LengthWidth-1:0] num_limit;
  logic [CountWidth-1:0]  arg_inc;
  logic [LengthWidth-1:0] left_dec;
  logic [1:0]             trailer_dec;

  assign advance      = in_valid && (!out_valid || result.ready);
  assign stream.ready = !in_valid || !out_valid || result.ready;

  assign num_limit = (st.phase == PH_CNT_NUM) ?
                     {{(LengthWidth-CountWidth){1'b0}}, count_limit} : length_limit;

  rac_number u_number (
    .data        (in_byte),
    .acc         (st.acc),
    .digits_seen (st.digits_seen),
    .sign_seen   (st.sign_seen),
    .limit       (num_limit),
    .step        (num)
  );

  assign arg_inc     = st.current_arg + 1'b1;
  assign left_dec    = st.bytes_left - 1'b1;
  assign trailer_dec = st.trailer_left - 1'b1;

  always_comb begin
    st_next  = st;
    res_next = '0;
    unique case (st.phase)
      PH_IDLE: begin
        if (in_byte == CH_STAR) begin
          st_next       = '0;
          st_next.phase = PH_CNT_NUM;
        end else begin
          res_next.error_code = ERR_TYPE;
        end
      end
      PH_CNT_NUM: begin
        res_next.error_code = num.err;
        st_next.acc         = num.acc;
        st_next.digits_seen = num.digits_seen;
        st_next.sign_seen   = num.sign_seen;
        if (num.at_cr) begin
          st_next.phase = PH_CNT_LF;
        end
      end
      PH_CNT_LF: begin
        if (in_byte != CH_LF) begin
          res_next.error_code = ERR_LF;
        end else begin
          st_next.args_total  = st.acc[CountWidth-1:0];
          st_next.current_arg = '0;
          res_next.arg_total  = st.acc[CountWidth-1:0];
          if (st.acc[CountWidth-1:0] == '0) begin
            res_next.command_done = 1'b1;
            st_next               = '0;
          end else begin
            st_next.phase = PH_ARG_TYPE;
          end
        end
      end
      PH_ARG_TYPE: begin
        if (in_byte == CH_DOLLAR) begin
          st_next.phase       = PH_LEN_NUM;
          st_next.acc         = '0;
          st_next.digits_seen = 1'b0;
          st_next.sign_seen   = 1'b0;
          res_next.arg_index  = st.current_arg[IndexWidth-1:0];
          res_next.arg_total  = st.args_total;
        end else begin
          res_next.error_code = ERR_TYPE;
        end
      end
      PH_LEN_NUM: begin
        res_next.error_code = num.err;
        res_next.arg_index  = st.current_arg[IndexWidth-1:0];
        res_next.arg_total  = st.args_total;
        st_next.acc         = num.acc;
        st_next.digits_seen = num.digits_seen;
        st_next.sign_seen   = num.sign_seen;
        if (num.at_cr) begin
          st_next.phase = PH_LEN_LF;
        end
      end
      PH_LEN_LF: begin
        if (in_byte != CH_LF) begin
          res_next.error_code = ERR_LF;
        end else begin
          res_next.arg_index   = st.current_arg[IndexWidth-1:0];
          res_next.arg_total   = st.args_total;
          st_next.bytes_left   = st.acc;
          st_next.trailer_left = 2'd2;
          st_next.phase        = (st.acc == '0) ? PH_TRAILER : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_next.payload_valid = 1'b1;
        res_next.payload_byte  = in_byte;
        res_next.arg_index     = st.current_arg[IndexWidth-1:0];
        res_next.arg_total     = st.args_total;
        st_next.bytes_left     = left_dec;
        if (left_dec == '0) begin
          st_next.trailer_left = 2'd2;
          st_next.phase        = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        res_next.arg_index   = st.current_arg[IndexWidth-1:0];
        res_next.arg_total   = st.args_total;
        st_next.trailer_left = trailer_dec;
        if (trailer_dec == '0) begin
          res_next.arg_done   = 1'b1;
          st_next.current_arg = arg_inc;
          if (arg_inc >= st.args_total) begin
            res_next.command_done = 1'b1;
            st_next               = '0;
          end else begin
            st_next.phase = PH_ARG_TYPE;
          end
        end
      end
    endcase
    if (res_next.error_code != ERR_NONE) begin
      st_next             = '0;
      res_next            = '0;
      res_next.error_code = (st.phase == PH_CNT_NUM || st.phase == PH_LEN_NUM) ?
                            num.err :
                            ((st.phase == PH_IDLE || st.phase == PH_ARG_TYPE) ?
                             ERR_TYPE : ERR_LF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (stream.valid && stream.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_byte <= stream.stream_byte;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.payload_valid = res.payload_valid;
  assign result.payload_byte  = res.payload_byte;
  assign result.arg_index     = res.arg_index;
  assign result.arg_done      = res.arg_done;
  assign result.command_done  = res.command_done;
  assign result.arg_total     = res.arg_total;
  assign result.error_code    = res.error_code;

endmodule

/* rtl/resp_array_command_parser.sv */
// Parser for arrays of bulk strings, one request byte per transfer.
// stream: valid/ready channel carrying stream_byte. Every accepted byte gives
//   exactly one item on result: payload bytes with their argument index,
//   arg_done on the last trailer byte of an argument, command_done on the byte
//   that ends the command, and an error_code that returns the parser to idle.
// Configuration: APB port, arg_count_limit at 0x0, arg_length_limit at 0x4;
//   write only while no request is in flight.
// Datapath: each accepted request is held in the input register, then one parse
//   step writes its result into the result register.
// Throughput: one request per clock while result.ready is high, with the parse
//   step updating the parser state from the registered byte.
// Stall: when result.ready is low the held result stays stable, the input
//   register holds at most one more request, and stream.ready stays low while
//   it is full until the result is taken.
// Reset (rst, synchronous): parser idle expecting '*', no result pending,
//   limits back to 1048576 and 536870912.
module resp_array_command_parser
  import rac_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  rac_byte_if.sink     stream,
  rac_result_if.source result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [CountWidth-1:0]  count_limit;
  logic [LengthWidth-1:0] length_limit;

  rac_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .count_limit  (count_limit),
    .length_limit (length_limit)
  );

  rac_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .count_limit  (count_limit),
    .length_limit (length_limit),
    .stream       (stream),
    .result       (result)
  );

endmodule

/* rtl/rac_checker.sv */
module rac_checker
  import rac_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        payload_valid,
  input logic [7:0]  payload_byte,
  input logic [19:0] arg_index,
  input logic        arg_done,
  input logic        command_done,
  input logic [20:0] arg_total,
  input logic [2:0]  error_code
);

  a_error_clears: assert property (@(posedge clk) disable iff (rst)
    valid && error_code != ERR_NONE |-> !payload_valid && !arg_done &&
      !command_done && arg_index == '0 && arg_total == '0)
    else $error("error result carries data");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> error_code <= ERR_LIMIT)
    else $error("unknown error code");

  a_payload_excl: assert property (@(posedge clk) disable iff (rst)
    valid && payload_valid |-> !arg_done && !command_done)
    else $error("payload byte flagged as end");

  a_cmd_end: assert property (@(posedge clk) disable iff (rst)
    valid && command_done && arg_total != '0 |-> arg_done)
    else $error("command ends without argument end");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(payload_byte) && $stable(arg_index) &&
      $stable(error_code))
    else $error("stalled result changed");

endmodule

bind resp_array_command_parser rac_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (result.valid),
  .ready         (result.ready),
  .payload_valid (result.payload_valid),
  .payload_byte  (result.payload_byte),
  .arg_index     (result.arg_index),
  .arg_done      (result.arg_done),
  .command_done  (result.command_done),
  .arg_total     (result.arg_total),
  .error_code    (result.error_code)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import rac_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam logic [31:0] CountAllOnes  = 32'h001F_FFFF;
  localparam logic [31:0] LengthAllOnes = 32'h3FFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COUNT, ST_COUNT_LF, ST_TYPE, ST_LENGTH, ST_LENGTH_LF, ST_DATA, ST_TRAIL
  } parse_state_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rac_byte_if   stream_if ();
  rac_result_if result_if ();

  resp_array_command_parser u_top (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // parser shadow state
  logic [CountWidth-1:0]  count_limit;
  logic [LengthWidth-1:0] length_limit;
  parse_state_t           state;
  logic [LengthWidth-1:0] num_acc;
  logic                   num_digits;
  logic                   num_neg;
  logic [CountWidth-1:0]  n_args;
  logic [CountWidth-1:0]  arg_no;
  logic [LengthWidth-1:0] data_left;
  logic [1:0]             trail_left;

  result_t    expected_q[$];
  logic [7:0] pending_bytes[$];
  result_t    want;
  result_t    predicted;
  logic       moved;

  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned errors_seen;
  int unsigned commands_seen;
  int unsigned payload_seen;
  int unsigned source_max;
  int unsigned sink_max;
  int unsigned sink_stall;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic void go_idle();
    state      = ST_IDLE;
    num_acc    = '0;
    num_digits = 1'b0;
    num_neg    = 1'b0;
    n_args     = '0;
    arg_no     = '0;
    data_left  = '0;
    trail_left = '0;
  endfunction

  function automatic void start_number(input parse_state_t next_state);
    state      = next_state;
    num_acc    = '0;
    num_digits = 1'b0;
    num_neg    = 1'b0;
  endfunction

  function automatic logic [2:0] number_char(input logic [7:0] b,
                                             input logic [LengthWidth-1:0] limit,
                                             output logic at_cr);
    logic [35:0] value;
    at_cr = 1'b0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      value = num_acc * 36'd10 + (b - CH_ZERO);
      if (value > {6'd0, limit}) return ERR_LIMIT;
      num_acc    = value[LengthWidth-1:0];
      num_digits = 1'b1;
      return ERR_NONE;
    end
    if (b == CH_MINUS && !num_digits && !num_neg) begin
      num_neg = 1'b1;
      return ERR_NONE;
    end
    if (b == CH_CR) begin
      if (!num_digits) return ERR_DIGIT;
      if (num_neg) return ERR_NEG;
      at_cr = 1'b1;
      return ERR_NONE;
    end
    return ERR_DIGIT;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b);
    result_t    r;
    logic [2:0] err;
    logic       at_cr;
    r     = '0;
    err   = ERR_NONE;
    at_cr = 1'b0;
    case (state)
      ST_COUNT: begin
        err = number_char(b, {9'd0, count_limit}, at_cr);
        if (err == ERR_NONE && at_cr) state = ST_COUNT_LF;
      end
      ST_COUNT_LF: begin
        if (b != CH_LF) begin
          err = ERR_LF;
        end else begin
          n_args      = num_acc[CountWidth-1:0];
          arg_no      = '0;
          r.arg_total = n_args;
          if (n_args == 0) begin
            r.command_done = 1'b1;
            go_idle();
          end else begin
            state = ST_TYPE;
          end
        end
      end
      ST_TYPE: begin
        if (b == CH_DOLLAR) begin
          start_number(ST_LENGTH);
          r.arg_index = arg_no[IndexWidth-1:0];
          r.arg_total = n_args;
        end else begin
          err = ERR_TYPE;
        end
      end
      ST_LENGTH: begin
        err = number_char(b, length_limit, at_cr);
        if (err == ERR_NONE) begin
          r.arg_index = arg_no[IndexWidth-1:0];
          r.arg_total = n_args;
          if (at_cr) state = ST_LENGTH_LF;
        end
      end
      ST_LENGTH_LF: begin
        if (b != CH_LF) begin
          err = ERR_LF;
        end else begin
          r.arg_index = arg_no[IndexWidth-1:0];
          r.arg_total = n_args;
          data_left   = num_acc;
          trail_left  = 2'd2;
          state       = (data_left == 0) ? ST_TRAIL : ST_DATA;
        end
      end
      ST_DATA: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.arg_index     = arg_no[IndexWidth-1:0];
        r.arg_total     = n_args;
        data_left       = data_left - 1'b1;
        if (data_left == 0) begin
          trail_left = 2'd2;
          state      = ST_TRAIL;
        end
      end
      ST_TRAIL: begin
        r.arg_index = arg_no[IndexWidth-1:0];
        r.arg_total = n_args;
        trail_left  = trail_left - 1'b1;
        if (trail_left == 0) begin
          r.arg_done = 1'b1;
          arg_no     = arg_no + 1'b1;
          if (arg_no >= n_args) begin
            r.command_done = 1'b1;
            go_idle();
          end else begin
            state = ST_TYPE;
          end
        end
      end
      default: begin
        if (b == CH_STAR) begin
          go_idle();
          start_number(ST_COUNT);
        end else begin
          err = ERR_TYPE;
        end
      end
    endcase
    if (err != ERR_NONE) begin
      go_idle();
      r            = '0;
      r.error_code = err;
    end
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_error($sformatf("result %0d %s: got %0h, expected %0h",
                             results_seen, name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (result_if.valid && result_if.ready) begin
        moved = 1'b1;
        results_seen++;
        if (expected_q.size() == 0) begin
          report_error($sformatf("result %0d arrived with no request pending",
                                 results_seen));
        end else begin
          want = expected_q.pop_front();
          check_field("payload_valid", 32'(result_if.payload_valid),
                      32'(want.payload_valid));
          check_field("payload_byte", 32'(result_if.payload_byte),
                      32'(want.payload_byte));
          check_field("arg_index", 32'(result_if.arg_index), 32'(want.arg_index));
          check_field("arg_done", 32'(result_if.arg_done), 32'(want.arg_done));
          check_field("command_done", 32'(result_if.command_done),
                      32'(want.command_done));
          check_field("arg_total", 32'(result_if.arg_total), 32'(want.arg_total));
          check_field("error_code", 32'(result_if.error_code), 32'(want.error_code));
        end
      end
      if (stream_if.valid && stream_if.ready) begin
        moved     = 1'b1;
        predicted = parse_byte(stream_if.stream_byte);
        expected_q.insert(expected_q.size(), predicted);
        if (predicted.error_code != ERR_NONE) errors_seen++;
        if (predicted.command_done) commands_seen++;
        if (predicted.payload_valid) payload_seen++;
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 QuietLimit, expected_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    result_if.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      sink_stall = $urandom_range(0, sink_max);
      if (sink_stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (sink_stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
    end
  end

  function automatic void add_byte(input logic [7:0] b);
    pending_bytes.insert(pending_bytes.size(), b);
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endfunction

  function automatic void add_line(input string s);
    add_str(s);
    add_crlf();
  endfunction

  function automatic void add_num(input int unsigned value);
    if ($urandom_range(0, 7) == 0) add_byte(CH_ZERO);
    add_str($sformatf("%0d", value));
  endfunction

  task automatic flush_bytes();
    logic [7:0]  b;
    int unsigned gap;
    while (pending_bytes.size() != 0) begin
      b   = pending_bytes.pop_front();
      gap = $urandom_range(0, source_max);
      if (gap > 0) begin
        stream_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      stream_if.valid       <= 1'b1;
      stream_if.stream_byte <= b;
      do @(posedge clk); while (!stream_if.ready);
      bytes_sent++;
    end
  endtask

  task automatic wait_drained();
    stream_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_COUNT_LIMIT) count_limit = value[CountWidth-1:0];
    else length_limit = value[LengthWidth-1:0];
  endtask

  task automatic set_limits(input logic [31:0] count_value, input logic [31:0] length_value);
    wait_drained();
    write_reg(REG_COUNT_LIMIT, count_value);
    write_reg(REG_LENGTH_LIMIT, length_value);
  endtask

  task automatic test_idle_junk();
    add_byte(8'h00);
    add_byte(8'hFF);
    add_str("A$");
    add_crlf();
    flush_bytes();
  endtask

  task automatic test_wellformed_commands();
    add_line("*2");
    add_line("$3");
    add_line("SET");
    add_line("$0");
    add_line("");
    add_line("*0");
    add_line("*000");
    add_line("*1");
    add_line("$4");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_CR);
    add_byte(CH_STAR);
    add_str("ab");
    flush_bytes();
  endtask

  task automatic test_number_errors();
    add_line("*-1");
    add_str("*-");
    add_byte(CH_CR);
    add_str("*--");
    add_str("*1-");
    add_str("*");
    add_byte(CH_CR);
    add_str("*-5x");
    add_str("*1");
    add_byte(CH_CR);
    add_str("X");
    add_line("*1");
    add_str("X");
    add_line("*1");
    add_line("$-1");
    add_line("*1");
    add_str("$5x");
    add_line("*1");
    add_str("$2");
    add_byte(CH_CR);
    add_str("Q");
    flush_bytes();
  endtask

  task automatic test_limit_extremes();
    set_limits(32'd0, 32'd0);
    add_line("*0");
    add_str("*1");
    flush_bytes();
    set_limits(32'd1, 32'd0);
    add_line("*1");
    add_line("$0");
    add_line("");
    add_line("*1");
    add_str("$1");
    add_str("*2");
    flush_bytes();
    set_limits(CountAllOnes, LengthAllOnes);
    add_line("*2097151");
    add_line("$1");
    add_line("A");
    add_str("Z");
    add_line("*1");
    add_str("$1073741823X");
    add_str("*2097152");
    add_line("*1");
    add_str("$1073741824");
    flush_bytes();
    set_limits({11'd0, COUNT_LIMIT_RESET}, {2'd0, LENGTH_LIMIT_RESET});
    add_line("*1048576");
    add_str("Q");
    add_str("*1048577");
    add_line("*1");
    add_str("$536870913");
    add_line("*1");
    add_str("$536870912x");
    flush_bytes();
  endtask

  // mostly well-formed commands with random payload, some corrupted on purpose
  task automatic test_random_traffic();
    int unsigned round_end;
    int unsigned n_cmd_args;
    int unsigned len;
    int unsigned pos;
    for (int round = 0; round < 4; round++) begin
      case (round)
        0: begin
          set_limits($urandom_range(4, 2097151), $urandom_range(8, 32'h3FFF_FFFF));
          source_max = 12;
          sink_max   = 12;
        end
        1: begin
          set_limits({11'd0, COUNT_LIMIT_RESET}, {2'd0, LENGTH_LIMIT_RESET});
          source_max = 0;
          sink_max   = 0;
        end
        2: begin
          set_limits($urandom_range(0, 3), $urandom_range(0, 8));
          source_max = 0;
          sink_max   = 12;
        end
        default: begin
          set_limits(CountAllOnes, LengthAllOnes);
          source_max = 12;
          sink_max   = 0;
        end
      endcase
      round_end = bytes_sent + 40;
      while (bytes_sent < round_end) begin
        n_cmd_args = $urandom_range(0, 4);
        add_byte(CH_STAR);
        add_num(n_cmd_args);
        add_crlf();
        repeat (n_cmd_args) begin
          len = $urandom_range(0, 8);
          add_byte(CH_DOLLAR);
          add_num(len);
          add_crlf();
          repeat (len) add_byte(8'($urandom));
          if ($urandom_range(0, 3) == 0) begin
            add_byte(8'($urandom));
            add_byte(8'($urandom));
          end else begin
            add_crlf();
          end
        end
        if ($urandom_range(0, 4) == 0) begin
          pos = $urandom_range(0, pending_bytes.size() - 1);
          case ($urandom_range(0, 2))
            0: pending_bytes[pos] = 8'($urandom);
            1: pending_bytes[pos] = CH_MINUS;
            default: begin
              while (pending_bytes.size() > pos) void'(pending_bytes.pop_back());
              add_byte(8'($urandom));
            end
          endcase
        end
        if ($urandom_range(0, 9) == 0) add_byte(8'($urandom));
        flush_bytes();
      end
    end
  endtask

  initial begin
    rst                   = 1'b1;
    stream_if.valid       = 1'b0;
    stream_if.stream_byte = 8'h00;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    fail_count            = 0;
    bytes_sent            = 0;
    results_seen          = 0;
    errors_seen           = 0;
    commands_seen         = 0;
    payload_seen          = 0;
    source_max            = 12;
    sink_max              = 12;
    count_limit           = COUNT_LIMIT_RESET;
    length_limit          = LENGTH_LIMIT_RESET;
    go_idle();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_idle_junk();
    test_wellformed_commands();
    test_number_errors();
    test_limit_extremes();
    test_random_traffic();

    wait_drained();
    repeat (8) @(posedge clk);
    if (expected_q.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_q.size()));
    $display("Sent %0d request bytes, checked %0d results: %0d commands, %0d payload bytes,",
             bytes_sent, results_seen, commands_seen, payload_seen);
    $display("%0d parse errors; limits swept from zero to full width under random stalls",
             errors_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
